// ----- rtl/hmpc_pkg.sv -----
// Package for the heart mask pixel compositor.
// Holds the fixed-point constants, the stage counts, the payload structs and the saturation helper.
package hmpc_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic signed [31:0] ONE    = 32'sd65536;
  localparam logic signed [31:0] EIGHTH = 32'sd8192;
  localparam logic [15:0]        K35    = 16'd39322;   // round(0.6 * ONE)

  localparam int CB_BITS   = 21;                       // floor cbrt(t * ONE^2) < 2^21
  localparam int FRONT_NST = 6;
  localparam int BACK_NST  = 4;
  localparam int NST       = FRONT_NST + CB_BITS + BACK_NST;

  typedef enum logic [1:0] {
    REG_INV_SCALE = 2'd0,
    REG_COL_STEP  = 2'd1,
    REG_ROW_STEP  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] fg_red;
    logic [7:0] fg_green;
    logic [7:0] fg_blue;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
  } pix_t;

  typedef struct packed {
    logic [30:0]        t;
    logic signed [31:0] a2;
    logic signed [31:0] b;
    pix_t               pix;
  } front_t;

  typedef struct packed {
    logic [CB_BITS-1:0] c;
    logic signed [31:0] a2;
    logic signed [31:0] b;
    pix_t               pix;
  } cb_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/heart_mask_pixel_compositor.sv -----
// Heart mask pixel compositor, top level: config registers, valid chain, three datapath parts.
// Depends on hmpc_pkg, hmpc_front, hmpc_cbrt and hmpc_back.
//
//  channel  | handshake             | word
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_stall   | col, row, fg_*, bg_*
//  out      | out_valid / out_stall | out_red, out_green, out_blue, inside_res
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word per clock unless out_stall holds a full pipe; 6 front, 21 cube-root bit stages, 4 back.
// Each stage holds its own valid bit and moves when it is empty or the stage after moves,
// so bubbles close up and words are still taken while a result waits on out_stall and a stage is empty.
// rst (synchronous) empties the pipe and restores the register reset values.
// cfg_ready is always high.
module heart_mask_pixel_compositor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] col,
  input  logic [11:0] row,
  input  logic [7:0]  fg_red,
  input  logic [7:0]  fg_green,
  input  logic [7:0]  fg_blue,
  input  logic [7:0]  bg_red,
  input  logic [7:0]  bg_green,
  input  logic [7:0]  bg_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        inside_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data
);
  import hmpc_pkg::*;

  logic [20:0]  inv_scale;
  logic [17:0]  col_step, row_step;
  logic [NST-1:0] v;     // stage valid bits
  logic [NST:0]   en;    // stage load enables, en[NST] is the output side
  pix_t         pix;
  front_t       f_out;
  cb_out_t      c_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_scale <= 21'd65536;
      col_step  <= 18'd32;
      row_step  <= 18'd32;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_INV_SCALE: inv_scale <= cfg_data;
        REG_COL_STEP:  col_step  <= cfg_data[17:0];
        REG_ROW_STEP:  row_step  <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // ready ripples back from the output
  always_comb begin
    en[NST] = !out_stall;
    for (int i = NST - 1; i >= 0; i--) en[i] = !v[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NST-1];

  assign pix = '{fg_red: fg_red, fg_green: fg_green, fg_blue: fg_blue,
                 bg_red: bg_red, bg_green: bg_green, bg_blue: bg_blue};

  hmpc_front u_front (
    .clk(clk), .en(en[FRONT_NST-1:0]), .col(col), .row(row), .pix(pix),
    .inv_scale(inv_scale), .col_step(col_step), .row_step(row_step), .dout(f_out)
  );

  hmpc_cbrt u_cbrt (
    .clk(clk), .en(en[FRONT_NST+CB_BITS-1:FRONT_NST]), .din(f_out), .dout(c_out)
  );

  hmpc_back u_back (
    .clk(clk), .en(en[NST-1:FRONT_NST+CB_BITS]), .din(c_out),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .inside_res(inside_res)
  );

  a_empty_out_takes: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall) else $error("input stalled with empty output stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v[0]) else $error("accepted word lost at stage 0");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    ((&v) && out_stall) |-> in_stall) else $error("word taken into a full pipe");

endmodule

// ----- rtl/hmpc_front.sv -----
// Front stages: pixel position to a, b, a^2 and 0.6*a^2.
// Depends on hmpc_pkg; enables come from the top-level valid chain.
module hmpc_front (
  input  logic                            clk,
  input  logic [hmpc_pkg::FRONT_NST-1:0]  en,
  input  logic [11:0]                     col,
  input  logic [11:0]                     row,
  input  hmpc_pkg::pix_t                  pix,
  input  logic [20:0]                     inv_scale,
  input  logic [17:0]                     col_step,
  input  logic [17:0]                     row_step,
  output hmpc_pkg::front_t                dout
);
  import hmpc_pkg::*;

  logic signed [31:0] u1, w1;
  pix_t               p1, p2, p3, p4, p5, p6;
  logic signed [53:0] pu2, pw2;
  logic signed [31:0] a3, b3, b4, b5, b6, a25, a26;
  logic signed [63:0] aa4;
  logic [46:0]        tp6;
  logic [29:0]        cprod, rprod;

  assign cprod = col * col_step;
  assign rprod = row * row_step;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u1 <= $signed({2'b00, cprod}) - ONE;
      w1 <= (ONE + EIGHTH) - $signed({2'b00, rprod});
      p1 <= pix;
    end
    if (en[1]) begin
      pu2 <= u1 * $signed({1'b0, inv_scale});
      pw2 <= w1 * $signed({1'b0, inv_scale});
      p2  <= p1;
    end
    if (en[2]) begin
      a3 <= sat32($signed({{10{pu2[53]}}, pu2}) >>> FRAC_BITS);
      b3 <= sat32($signed({{10{pw2[53]}}, pw2}) >>> FRAC_BITS);
      p3 <= p2;
    end
    if (en[3]) begin
      aa4 <= a3 * a3;
      b4  <= b3;
      p4  <= p3;
    end
    if (en[4]) begin
      a25 <= sat32(aa4 >>> FRAC_BITS);
      b5  <= b4;
      p5  <= p4;
    end
    if (en[5]) begin
      tp6 <= a25[30:0] * K35;   // a2 is never negative
      a26 <= a25;
      b6  <= b5;
      p6  <= p5;
    end
  end

  assign dout.t   = tp6[46:16];
  assign dout.a2  = a26;
  assign dout.b   = b6;
  assign dout.pix = p6;

endmodule

// ----- rtl/hmpc_cbrt.sv -----
// Bit-per-stage floor cube root of t * 2^32, carrying c, c^2, c^3 as shift-and-add terms.
// Depends on hmpc_pkg.
module hmpc_cbrt (
  input  logic                          clk,
  input  logic [hmpc_pkg::CB_BITS-1:0]  en,
  input  hmpc_pkg::front_t              din,
  output hmpc_pkg::cb_out_t             dout
);
  import hmpc_pkg::*;

  logic [CB_BITS-1:0] c_q  [CB_BITS];
  logic [41:0]        c2_q [CB_BITS];
  logic [62:0]        c3_q [CB_BITS];
  front_t             d_q  [CB_BITS];

  for (genvar j = 0; j < CB_BITS; j++) begin : g_st
    localparam int K = CB_BITS - 1 - j;
    logic [CB_BITS-1:0] c_in;
    logic [41:0]        c2_in;
    logic [62:0]        c3_in;
    front_t             d_in;
    logic [66:0]        t2, s3, s2, s1, cand3, tgt;
    logic [41:0]        c2_new;

    if (j == 0) begin : g_first
      assign c_in  = '0;
      assign c2_in = '0;
      assign c3_in = '0;
      assign d_in  = din;
    end else begin : g_next
      assign c_in  = c_q[j-1];
      assign c2_in = c2_q[j-1];
      assign c3_in = c3_q[j-1];
      assign d_in  = d_q[j-1];
    end

    always_comb begin
      t2     = {25'b0, c2_in} << K;
      s1     = {46'b0, c_in} << (2 * K);
      s2     = (t2 << 1) + t2;
      s3     = (s1 << 1) + s1;
      cand3  = {4'b0, c3_in} + s2 + s3 + (67'd1 << (3 * K));
      tgt    = {4'b0, d_in.t, 32'b0};
      c2_new = c2_in + 42'({21'b0, c_in} << (K + 1)) + (42'd1 << (2 * K));
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        d_q[j] <= d_in;
        if (cand3 <= tgt) begin
          c_q[j]  <= c_in | (CB_BITS'(1) << K);
          c2_q[j] <= c2_new;
          c3_q[j] <= cand3[62:0];
        end else begin
          c_q[j]  <= c_in;
          c2_q[j] <= c2_in;
          c3_q[j] <= c3_in;
        end
      end
    end
  end

  assign dout.c   = c_q[CB_BITS-1];
  assign dout.a2  = d_q[CB_BITS-1].a2;
  assign dout.b   = d_q[CB_BITS-1].b;
  assign dout.pix = d_q[CB_BITS-1].pix;

endmodule

// ----- rtl/hmpc_back.sv -----
// Back stages: d = c - b, m = 2*d*b, inside test and pixel select.
// Depends on hmpc_pkg.
module hmpc_back (
  input  logic                           clk,
  input  logic [hmpc_pkg::BACK_NST-1:0]  en,
  input  hmpc_pkg::cb_out_t              din,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic                           inside_res
);
  import hmpc_pkg::*;

  logic signed [31:0] d1, b1, a21, a22, a23, m3;
  logic signed [63:0] db2;
  pix_t               p1, p2, p3;
  logic signed [32:0] sum;
  logic               ins;

  assign sum = {a23[31], a23} + {m3[31], m3};
  assign ins = (sum <= 33'sd65536);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1  <= sat32($signed({43'b0, din.c}) - {{32{din.b[31]}}, din.b});
      b1  <= din.b;
      a21 <= din.a2;
      p1  <= din.pix;
    end
    if (en[1]) begin
      db2 <= d1 * b1;
      a22 <= a21;
      p2  <= p1;
    end
    if (en[2]) begin
      m3  <= sat32(db2 >>> (FRAC_BITS - 1));
      a23 <= a22;
      p3  <= p2;
    end
    if (en[3]) begin
      inside_res <= ins;
      out_red    <= ins ? p3.fg_red   : p3.bg_red;
      out_green  <= ins ? p3.fg_green : p3.bg_green;
      out_blue   <= ins ? p3.fg_blue  : p3.bg_blue;
    end
  end

endmodule

// ----- tb/sv/hmpc_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the heart mask pixel compositor: tracks register writes, predicts each pixel.
// Depends on hmpc_pkg for the register indexes.
module hmpc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [11:0] col,
  input  logic [11:0] row,
  input  logic [7:0]  fg_red,
  input  logic [7:0]  fg_green,
  input  logic [7:0]  fg_blue,
  input  logic [7:0]  bg_red,
  input  logic [7:0]  bg_green,
  input  logic [7:0]  bg_blue,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic        inside_res,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data,
  output int          fails,
  output int          pending
);
  import hmpc_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       in_mask;
  } pixel_out_t;

  pixel_out_t  pixel_q[$];
  logic [20:0] m_inv_scale;
  logic [17:0] m_col_step;
  logic [17:0] m_row_step;

  localparam longint FIX_ONE = 64'sd65536;
  localparam longint FIX_K35 = (3 * FIX_ONE + 2) / 5;

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // floor cube root of t * ONE^2; the result stays below 2^21
  function automatic longint cube_root_fix(longint t);
    longint unsigned target;
    longint unsigned c;
    longint unsigned cand;
    target = longint'(t) << 32;
    c = 0;
    for (int bit_n = 20; bit_n >= 0; bit_n--) begin
      cand = c | (64'd1 << bit_n);
      if (cand * cand * cand <= target) c = cand;
    end
    return longint'(c);
  endfunction

  function automatic logic heart_inside(logic [11:0] cx, logic [11:0] ry);
    longint is, u, v, a, b, a2, t, c, d, m, f;
    is = longint'(m_inv_scale);
    u  = clamp32(longint'(cx) * longint'(m_col_step) - FIX_ONE);
    v  = clamp32(FIX_ONE - longint'(ry) * longint'(m_row_step));
    a  = clamp32((u * is) >>> 16);
    b  = clamp32((clamp32(v + FIX_ONE / 8) * is) >>> 16);
    a2 = clamp32((a * a) >>> 16);
    t  = clamp32((a2 * FIX_K35) >>> 16);
    c  = cube_root_fix(t);
    d  = clamp32(c - b);
    m  = clamp32((d * b) >>> 15);
    f  = clamp32(clamp32(a2 + m) - FIX_ONE);
    return f <= 0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    pixel_out_t want;
    if (rst) begin
      m_inv_scale = 21'd65536;
      m_col_step  = 18'd32;
      m_row_step  = 18'd32;
      pixel_q.delete();
    end else begin
      // outputs first: a word taken this edge cannot leave at the same edge
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("words queued", 0, 1);
        end else begin
          want = pixel_q.pop_front();
          if (out_red !== want.red) report_mismatch("out_red", out_red, want.red);
          if (out_green !== want.green) report_mismatch("out_green", out_green, want.green);
          if (out_blue !== want.blue) report_mismatch("out_blue", out_blue, want.blue);
          if (inside_res !== want.in_mask)
            report_mismatch("inside_res", inside_res, want.in_mask);
        end
      end
      if (in_valid && !in_stall) begin
        want.in_mask = heart_inside(col, row);
        want.red     = want.in_mask ? fg_red : bg_red;
        want.green   = want.in_mask ? fg_green : bg_green;
        want.blue    = want.in_mask ? fg_blue : bg_blue;
        pixel_q.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INV_SCALE: m_inv_scale = cfg_data;
          REG_COL_STEP:  m_col_step  = cfg_data[17:0];
          REG_ROW_STEP:  m_row_step  = cfg_data[17:0];
          default: ;
        endcase
      end
    end
    pending = pixel_q.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the heart mask pixel compositor: clock, reset, stimulus and verdict.
// Depends on hmpc_pkg, the block and hmpc_checker.
module tb;
  import hmpc_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;   // no register here, write must be dropped
  localparam int PIPE_DEPTH = 31;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [11:0] col;
  logic [11:0] row;
  logic [7:0]  fg_red, fg_green, fg_blue;
  logic [7:0]  bg_red, bg_green, bg_blue;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_red, out_green, out_blue;
  logic        inside_res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [20:0] cfg_data;
  int          fails;
  int          pending;

  // receiver controls
  bit quiet;          // no idling in the last part of the run
  bit hold_request;   // asks the sink for one long hold-off

  heart_mask_pixel_compositor uut (
    .clk, .rst, .in_valid, .in_stall, .col, .row,
    .fg_red, .fg_green, .fg_blue, .bg_red, .bg_green, .bg_blue,
    .out_valid, .out_stall, .out_red, .out_green, .out_blue, .inside_res,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  hmpc_checker chk (
    .clk, .rst, .in_valid, .in_stall, .col, .row,
    .fg_red, .fg_green, .fg_blue, .bg_red, .bg_green, .bg_blue,
    .out_valid, .out_stall, .out_red, .out_green, .out_blue, .inside_res,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fails, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // generous cap; a correct run needs well under a millisecond
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // sink: random stall bursts, one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        for (int i = 0; i < 300; i++) @(negedge clk);
        hold_request = 1'b0;
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 15);
        out_stall = $urandom_range(0, 1);
        for (int i = 1; i < n; i++) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // one word on the pixel channel; valid stays up into the next word
  task automatic send_pixel(logic [11:0] cx, logic [11:0] ry, logic [23:0] fg, logic [23:0] bg);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    col = cx;
    row = ry;
    {fg_red, fg_green, fg_blue} = fg;
    {bg_red, bg_green, bg_blue} = bg;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [20:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random pixel: mostly inside the configured frame, sometimes anywhere
  task automatic random_pixel(int width, int height);
    logic [11:0] cx, ry;
    cx = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, width - 1));
    ry = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, height - 1));
    send_pixel(cx, ry, 24'($urandom), 24'($urandom));
  endtask

  initial begin
    int width, height;
    logic [20:0] scale;
    logic [17:0] cstep, rstep;
    rst = 1'b1;
    in_valid = 1'b0;
    col = '0; row = '0;
    fg_red = '0; fg_green = '0; fg_blue = '0;
    bg_red = '0; bg_green = '0; bg_blue = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_INV_SCALE;
    cfg_data = '0;
    quiet = 1'b0;
    hold_request = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, corners of position and colour
    send_pixel(12'd0, 12'd0, 24'hFFFFFF, 24'h000000);
    send_pixel(12'd4095, 12'd4095, 24'h000000, 24'hFFFFFF);
    send_pixel(12'd4095, 12'd0, 24'hFF00FF, 24'h00FF00);
    send_pixel(12'd0, 12'd4095, 24'h00FF00, 24'hFF00FF);
    send_pixel(12'd2048, 12'd2048, 24'hAA55AA, 24'h55AA55);
    send_pixel(12'd2048, 12'd1600, 24'h123456, 24'h654321);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      width = 64;
      height = 64;
      case (ph)
        0: begin scale = 21'd0;       cstep = 18'd2080;   rstep = 18'd2080; end  // all inside
        1: begin scale = 21'h1FFFFF;  cstep = 18'h3FFFF;  rstep = 18'h3FFFF; end  // saturation
        2: begin scale = 21'd65536;   cstep = 18'd0;      rstep = 18'd0;     end  // one point
        3: begin scale = 21'd78643;   cstep = 18'd2080;   rstep = 18'd2080;  end
        4: begin scale = 21'd1966080; cstep = 18'd131072; rstep = 18'd131072;
                 width = 4; height = 4; end
        5: begin scale = 21'd65536;   cstep = 18'd32;     rstep = 18'd32;
                 width = 4096; height = 4096; end
        6: begin scale = 21'($urandom_range(65536, 1966080));
                 cstep = 18'($urandom_range(0, 131072));
                 rstep = 18'($urandom_range(0, 131072)); end
        default: begin scale = 21'd98304; cstep = 18'd1040; rstep = 18'd1040;
                 width = 127; height = 127; end
      endcase
      write_reg(REG_INV_SCALE, scale);
      write_reg(REG_COL_STEP, 21'(cstep));
      write_reg(REG_ROW_STEP, 21'(rstep));
      write_reg(REG_UNUSED, 21'($urandom));
      if (ph == 7) quiet = 1'b1;
      // byte extremes against the current mask
      send_pixel(12'd0, 12'd0, 24'h000000, 24'hFFFFFF);
      send_pixel(12'(width / 2), 12'(height / 2), 24'hFFFFFF, 24'h000000);
      if (ph == 3) hold_request = 1'b1;   // sink holds off, pipe fills, input stalls
      for (int i = 0; i < 150; i++) random_pixel(width, height);
      drain();   // sender waits for every result before the next setting
    end

    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- heart_mask_pixel_compositor.f -----
rtl/hmpc_pkg.sv
rtl/hmpc_front.sv
rtl/hmpc_cbrt.sv
rtl/hmpc_back.sv
rtl/heart_mask_pixel_compositor.sv
tb/sv/hmpc_checker.sv
tb/sv/tb.sv
